// File: design/sfd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// sensor frame deframer. No dependencies.
package sfd_pkg;

	localparam int NUM_FIELDS  = 24;
	localparam int STORE_DEPTH = 128;

	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W   = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
	localparam int SUM_W   = $clog2(3 * NUM_FIELDS + 1);
	localparam int CMP_W   = ((CNT_W > SUM_W) ? CNT_W : SUM_W) + 1;
	localparam int CFG_W   = 48;
	localparam int VAL_W   = 24;
	localparam int CHIDX_W = 5;
	localparam int ST_W    = 2;

	localparam logic [7:0] START_BYTE = 8'hA0;
	localparam logic [7:0] END_B0     = 8'hC0;
	localparam logic [7:0] END_B1     = 8'h0D;
	localparam logic [7:0] END_B2     = 8'h0A;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_SIZE = 2'd1;
	localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic            start;
		logic            store;
		logic            walk_init;
		logic            sum_step;
		logic            emit_init;
		logic            skip;
		logic            val_clear;
		logic            take;
		logic            load_field;
		logic            load_err;
		logic            set_err;
		logic [ST_W-1:0] err_code;
	} cmd_t;

	typedef struct packed {
		logic       hit_start;
		logic       done;
		logic       full;
		logic [1:0] w;
		logic       idx_end;
		logic       size_ok;
		logic       any;
		logic       byte_last;
		logic       is_last;
		logic       out_free;
	} stat_t;

endpackage

// File: design/sensor_frame_deframer_top.sv
// Sensor frame deframer top level: controller plus datapath.
// Depends on sfd_pkg, sfd_ctrl and sfd_dp.
//
//  channel   handshake             payload
//  input     in_valid / in_stall   data_byte
//  output    out_valid / out_stall channel_value, channel_index, status, last
//  config    cfg_we                cfg_data (field widths)
//
// One byte per cycle while hunting or collecting. At frame end the controller
// walks all NUM_FIELDS widths (one per cycle) to size-check the frame, then
// walks the fields again: it skips each disabled field, reads the stored bytes
// of each enabled field through the single frame store read port and emits its
// result. Input is stalled during both walks and while an error result waits
// for the output register. The frame store needs no clearing after reset.
module sensor_frame_deframer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfd_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       data_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [sfd_pkg::VAL_W-1:0] channel_value,
	output logic [sfd_pkg::CHIDX_W-1:0]      channel_index,
	output logic [sfd_pkg::ST_W-1:0]         status,
	output logic                             last
);

	sfd_pkg::cmd_t  cmd;
	sfd_pkg::stat_t stat;

	sfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sfd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.data_byte     (data_byte),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.channel_value (channel_value),
		.channel_index (channel_index),
		.status        (status),
		.last          (last)
	);

`ifndef ASSERT_OFF
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != sfd_pkg::ST_OK)) |->
		(last && (channel_index == '0) && (channel_value == '0)))
		else $error("error result with field payload");

	a_walk_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == sfd_pkg::ST_OK) && !last) |-> in_stall)
		else $error("input taken in the middle of a field walk");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (channel_index <= sfd_pkg::CHIDX_W'(sfd_pkg::NUM_FIELDS - 1)))
		else $error("channel index out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_field || cmd.load_err) |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");
`endif

endmodule

// File: design/sfd_ctrl.sv
// Frame deframer controller: hunt/collect sequencing and the two frame-end walks.
// Depends on sfd_pkg.
module sfd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  sfd_pkg::stat_t stat,
	output sfd_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_HUNT    = 4'd0;
	localparam logic [3:0] S_COLLECT = 4'd1;
	localparam logic [3:0] S_SUM     = 4'd2;
	localparam logic [3:0] S_CHECK   = 4'd3;
	localparam logic [3:0] S_FIELD   = 4'd4;
	localparam logic [3:0] S_TAKE    = 4'd5;
	localparam logic [3:0] S_ADDR    = 4'd6;
	localparam logic [3:0] S_EMIT    = 4'd7;
	localparam logic [3:0] S_ERR     = 4'd8;

	logic [3:0] state_q, state_d;
	logic       acc;

	assign in_stall = !((state_q == S_HUNT) || (state_q == S_COLLECT));
	assign acc      = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_HUNT: begin
				if (acc && stat.hit_start) begin
					cmd.start = 1'b1;
					state_d   = S_COLLECT;
				end
			end
			S_COLLECT: begin
				if (acc) begin
					cmd.store = 1'b1;
					if (stat.done) begin
						cmd.walk_init = 1'b1;
						state_d       = S_SUM;
					end else if (stat.full) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = sfd_pkg::ST_OVF;
						state_d      = S_ERR;
					end
				end
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (stat.idx_end) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!stat.size_ok) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = sfd_pkg::ST_SIZE;
					state_d      = S_ERR;
				end else if (!stat.any) begin
					state_d = S_HUNT;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = S_FIELD;
				end
			end
			S_FIELD: begin
				if (stat.w == 2'd0) begin
					cmd.skip = 1'b1;
				end else begin
					cmd.val_clear = 1'b1;
					state_d       = S_TAKE;
				end
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				state_d  = stat.byte_last ? S_EMIT : S_ADDR;
			end
			S_ADDR: state_d = S_TAKE;
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.load_field = 1'b1;
					if (stat.is_last) begin
						state_d = S_HUNT;
					end else begin
						cmd.skip = 1'b1;
						state_d  = S_FIELD;
					end
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.load_err = 1'b1;
					state_d      = S_HUNT;
				end
			end
			default: state_d = S_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_HUNT;
		else         state_q <= state_d;
	end

endmodule

// File: design/sfd_dp.sv
// Frame deframer datapath: width register, frame store, end matcher, field
// assembly and result register. Depends on sfd_pkg.
module sfd_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sfd_pkg::CFG_W-1:0]            cfg_data,
	input  logic [7:0]                           data_byte,
	input  sfd_pkg::cmd_t                        cmd,
	output sfd_pkg::stat_t                       stat,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [sfd_pkg::VAL_W-1:0]     channel_value,
	output logic [sfd_pkg::CHIDX_W-1:0]          channel_index,
	output logic [sfd_pkg::ST_W-1:0]             status,
	output logic                                 last
);

	logic [7:0]                    mem [sfd_pkg::STORE_DEPTH];
	logic [7:0]                    rd_q;
	logic [sfd_pkg::CFG_W-1:0]     widths_q;
	logic [sfd_pkg::CNT_W-1:0]     count_q;
	logic [1:0]                    prog_q;
	logic [sfd_pkg::IDX_W-1:0]     idx_q;
	logic [sfd_pkg::IDX_W-1:0]     last_idx_q;
	logic [sfd_pkg::SUM_W-1:0]     sum_q;
	logic [sfd_pkg::SUM_W-1:0]     pos_q;
	logic                          any_q;
	logic [1:0]                    bcnt_q;
	logic [sfd_pkg::VAL_W-1:0]     val_q;
	logic [sfd_pkg::ST_W-1:0]      err_q;
	logic                          out_valid_q;
	logic [sfd_pkg::VAL_W-1:0]     ch_value_q;
	logic [sfd_pkg::CHIDX_W-1:0]   ch_index_q;
	logic [sfd_pkg::ST_W-1:0]      status_q;
	logic                          last_q;
	logic [1:0]                    w;
	logic                          idx_end;

	assign w       = widths_q[{idx_q, 1'b0} +: 2];
	assign idx_end = (idx_q == sfd_pkg::IDX_W'(sfd_pkg::NUM_FIELDS - 1));

	always_comb begin
		stat           = '0;
		stat.hit_start = (data_byte == sfd_pkg::START_BYTE);
		stat.done      = (prog_q == 2'd2) && (data_byte == sfd_pkg::END_B2);
		stat.full      = (count_q == sfd_pkg::CNT_W'(sfd_pkg::STORE_DEPTH - 1));
		stat.w         = w;
		stat.idx_end   = idx_end;
		stat.size_ok   = (sfd_pkg::CMP_W'(count_q) ==
		                  (sfd_pkg::CMP_W'(sum_q) + sfd_pkg::CMP_W'(3)));
		stat.any       = any_q;
		stat.byte_last = (2'(bcnt_q + 2'd1) == w);
		stat.is_last   = (idx_q == last_idx_q);
		stat.out_free  = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.store) mem[count_q[sfd_pkg::ADDR_W-1:0]] <= data_byte;
		rd_q <= mem[sfd_pkg::ADDR_W'(pos_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widths_q <= '0;
			count_q  <= '0;
			prog_q   <= 2'd0;
		end else begin
			if (cfg_we) widths_q <= cfg_data;
			if (cmd.start) begin
				count_q <= '0;
				prog_q  <= 2'd0;
			end else if (cmd.store) begin
				count_q <= count_q + 1'b1;
				if ((prog_q == 2'd1) && (data_byte == sfd_pkg::END_B1)) prog_q <= 2'd2;
				else if (data_byte == sfd_pkg::END_B0)                   prog_q <= 2'd1;
				else                                                     prog_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init || cmd.emit_init) idx_q <= '0;
		else if ((cmd.sum_step || cmd.skip) && !idx_end) idx_q <= idx_q + 1'b1;
		if (cmd.walk_init) begin
			sum_q <= '0;
			any_q <= 1'b0;
		end else if (cmd.sum_step) begin
			sum_q <= sum_q + sfd_pkg::SUM_W'(w);
			if (w != 2'd0) begin
				any_q      <= 1'b1;
				last_idx_q <= idx_q;
			end
		end
		if (cmd.emit_init) pos_q <= '0;
		else if (cmd.take) pos_q <= pos_q + 1'b1;
		if (cmd.val_clear) begin
			val_q  <= '0;
			bcnt_q <= 2'd0;
		end else if (cmd.take) begin
			val_q  <= {val_q[sfd_pkg::VAL_W-9:0], rd_q};
			bcnt_q <= bcnt_q + 2'd1;
		end
		if (cmd.set_err) err_q <= cmd.err_code;
		if (cmd.load_field) begin
			ch_value_q <= val_q;
			ch_index_q <= sfd_pkg::CHIDX_W'(idx_q);
			status_q   <= sfd_pkg::ST_OK;
			last_q     <= (idx_q == last_idx_q);
		end else if (cmd.load_err) begin
			ch_value_q <= '0;
			ch_index_q <= '0;
			status_q   <= err_q;
			last_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                           out_valid_q <= 1'b0;
		else if (cmd.load_field || cmd.load_err) out_valid_q <= 1'b1;
		else if (!out_stall)                   out_valid_q <= 1'b0;
	end

	assign out_valid     = out_valid_q;
	assign channel_value = ch_value_q;
	assign channel_index = ch_index_q;
	assign status        = status_q;
	assign last          = last_q;

endmodule
